// File: sv/svnco_pkg.sv
// ----------------------------------------------------------------------------
// svnco_pkg: shared types and constants for the synth voice core
// Stage, opcode, waveform and register index codes, fixed constants and the
// quarter-wave sine table computed at elaboration.
// ----------------------------------------------------------------------------
package svnco_pkg;

	// Oscillator
	localparam int PHASE_BITS      = 15;
	localparam int SAMPLE_BITS     = 16;
	localparam int STEP_BITS       = 31;
	localparam int SUSTAIN_BITS    = 15;
	localparam int CFG_INDEX_BITS  = 3;
	localparam int CFG_DATA_BITS   = 31;

	// Default envelope fraction bits below the Q15 level
	localparam int LEVEL_FRAC_BITS = 16;

	// Sine table: full period of SINE_TABLE_SIZE points (power of two),
	// stored as one quarter of SINE_QTR + 1 points
	localparam int SINE_TABLE_SIZE = 512;
	localparam int SINE_IDX_BITS   = $clog2(SINE_TABLE_SIZE);
	localparam int SINE_QTR        = SINE_TABLE_SIZE / 4;

	// Wave and scaling constants
	localparam logic [15:0] WAVE_MAX    = 16'h7fff;
	localparam logic [15:0] WAVE_MIN    = 16'h8000;
	localparam logic [14:0] SQUARE_EDGE = 15'h3fff;
	localparam logic [31:0] DIV_DEN     = 32'd32767;

	// Register reset values
	localparam logic [STEP_BITS-1:0]    ATTACK_STEP_RST  = 31'd44737877;
	localparam logic [STEP_BITS-1:0]    DECAY_STEP_RST   = 31'd0;
	localparam logic [STEP_BITS-1:0]    RELEASE_STEP_RST = 31'd44737877;
	localparam logic [SUSTAIN_BITS-1:0] SUSTAIN_RST      = 15'h7fff;

	typedef enum logic [2:0] {
		ENV_IDLE    = 3'd0,
		ENV_ATTACK  = 3'd1,
		ENV_DECAY   = 3'd2,
		ENV_SUSTAIN = 3'd3,
		ENV_RELEASE = 3'd4
	} env_stage_t;

	typedef enum logic [1:0] {
		OP_TICK     = 2'd0,
		OP_NOTE_ON  = 2'd1,
		OP_NOTE_OFF = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		WAVE_SINE   = 2'd0,
		WAVE_SQUARE = 2'd1,
		WAVE_SAW    = 2'd2
	} wave_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_WAVE_TYPE     = 3'd0,
		CFG_ATTACK_STEP   = 3'd1,
		CFG_DECAY_STEP    = 3'd2,
		CFG_RELEASE_STEP  = 3'd3,
		CFG_SUSTAIN_LEVEL = 3'd4
	} cfg_index_t;

	typedef logic [14:0] qtab_t [0:SINE_QTR];

	// Quarter-wave table, entry k = round(32767*sin(pi/2 * k/SINE_QTR)),
	// Q30 Taylor series to x^13, clamped to [0,1] before rounding
	function automatic qtab_t build_sine_qtab();
		qtab_t             tab;
		longint unsigned   x;
		longint unsigned   x2;
		longint unsigned   term;
		longint unsigned   v;
		longint            sum;
		longint unsigned   num;
		longint unsigned   half_pi;
		longint            one;
		half_pi = 64'd1686629713;
		one     = 64'sd1 <<< 30;
		for (int k = 0; k <= SINE_QTR; k++) begin
			num  = 64'(4 * k);
			x    = (half_pi * num) / SINE_TABLE_SIZE;
			x2   = (x * x) >> 30;
			term = x;
			sum  = longint'(x);
			term = ((term * x2) >> 30) / 6;
			sum  = sum - longint'(term);
			term = ((term * x2) >> 30) / 20;
			sum  = sum + longint'(term);
			term = ((term * x2) >> 30) / 42;
			sum  = sum - longint'(term);
			term = ((term * x2) >> 30) / 72;
			sum  = sum + longint'(term);
			term = ((term * x2) >> 30) / 110;
			sum  = sum - longint'(term);
			term = ((term * x2) >> 30) / 156;
			sum  = sum + longint'(term);
			if (sum < 0)
				sum = 0;
			if (sum > one)
				sum = one;
			v      = ((unsigned'(sum) * 64'd32767) + (64'd1 << 29)) >> 30;
			tab[k] = 15'(v);
		end
		return tab;
	endfunction

	localparam qtab_t SINE_QTAB = build_sine_qtab();

endpackage

// File: sv/synth_voice_nco_with_adsr_core.sv
// ----------------------------------------------------------------------------
// synth_voice_nco_with_adsr_core: one synthesizer voice
// Phase accumulator oscillator (sine, square, saw) scaled by an ADSR
// envelope held in Q15 fixed point with extra fraction bits.
// ----------------------------------------------------------------------------
// A sample tick's result is registered through stages s1 to s5 and then the output register.
// Throughput: one item per cycle from the six-stage sample pipeline; bubbles
//   collapse, so a stalled result blocks input only when every stage is full.
// Note on / note off items update state at acceptance and produce no result.
// Reset (arst_n low, asynchronous): voice idle, phase, step and level zero,
//   registers at their defaults, pipeline empty.
// ----------------------------------------------------------------------------
module synth_voice_nco_with_adsr_core #(
	parameter int LEVEL_FRAC_BITS = svnco_pkg::LEVEL_FRAC_BITS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,

	// configuration write port
	input  logic                                  cfg_we,
	input  logic [svnco_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [svnco_pkg::CFG_DATA_BITS-1:0]   cfg_data,

	// input items
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [1:0]                            op,
	input  logic [svnco_pkg::PHASE_BITS-1:0]      phase_increment,

	// result items
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [svnco_pkg::SAMPLE_BITS-1:0] sample_out,
	output logic [2:0]                            envelope_stage_out
);

	// Level is Q15 with LEVEL_FRAC_BITS more fraction bits.
	localparam int LW  = 15 + LEVEL_FRAC_BITS;
	// Envelope arithmetic width: room for level + step without wrap.
	localparam int SW  = ((LW > svnco_pkg::STEP_BITS) ? LW : svnco_pkg::STEP_BITS) + 1;
	// wave (16 signed) times level (unsigned)
	localparam int PW  = LW + 17;
	localparam int IB  = svnco_pkg::SINE_IDX_BITS;
	localparam logic [SW-1:0] LVL_MAX = SW'(32'h7fff) << LEVEL_FRAC_BITS;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [1:0]                          wave_type_q;
	logic [svnco_pkg::STEP_BITS-1:0]     attack_step_q;
	logic [svnco_pkg::STEP_BITS-1:0]     decay_step_q;
	logic [svnco_pkg::STEP_BITS-1:0]     release_step_q;
	logic [svnco_pkg::SUSTAIN_BITS-1:0]  sustain_level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_type_q     <= svnco_pkg::WAVE_SINE;
			attack_step_q   <= svnco_pkg::ATTACK_STEP_RST;
			decay_step_q    <= svnco_pkg::DECAY_STEP_RST;
			release_step_q  <= svnco_pkg::RELEASE_STEP_RST;
			sustain_level_q <= svnco_pkg::SUSTAIN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				svnco_pkg::CFG_WAVE_TYPE:     wave_type_q     <= cfg_data[1:0];
				svnco_pkg::CFG_ATTACK_STEP:   attack_step_q   <= cfg_data;
				svnco_pkg::CFG_DECAY_STEP:    decay_step_q    <= cfg_data;
				svnco_pkg::CFG_RELEASE_STEP:  release_step_q  <= cfg_data;
				svnco_pkg::CFG_SUSTAIN_LEVEL: sustain_level_q <= cfg_data[14:0];
				default: ;  // unmapped index, write dropped
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Handshake: bubble-collapsing ready chain through the sample pipeline
	// ------------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5, out_valid_q;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_out;

	assign rdy_out  = !out_valid_q || out_ready;
	assign rdy_s5   = !v_s5 || rdy_out;
	assign rdy_s4   = !v_s4 || rdy_s5;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	logic accept;
	logic tick_acc;
	assign accept   = in_valid && in_ready;
	assign tick_acc = accept && (op == svnco_pkg::OP_TICK);

	// ------------------------------------------------------------------
	// Voice state: phase accumulator and envelope
	// ------------------------------------------------------------------
	logic [svnco_pkg::PHASE_BITS-1:0] phase_q;
	logic [svnco_pkg::PHASE_BITS-1:0] phase_step_q;
	logic [LW-1:0]                    level_q;
	svnco_pkg::env_stage_t            stage_q;

	// Envelope step for one tick (next state)
	logic [LW-1:0]          level_d;
	svnco_pkg::env_stage_t  stage_d;
	logic [SW-1:0]          lvl_ext;
	logic [SW-1:0]          att_sum;
	logic [SW-1:0]          dec_ext;
	logic [SW-1:0]          rel_ext;
	logic [SW-1:0]          sus_ext;
	logic [SW-1:0]          dec_lvl;

	always_comb begin
		lvl_ext = SW'(level_q);
		att_sum = lvl_ext + SW'(attack_step_q);
		dec_ext = SW'(decay_step_q);
		rel_ext = SW'(release_step_q);
		sus_ext = SW'(sustain_level_q) << LEVEL_FRAC_BITS;
		// decay saturates at zero
		dec_lvl = (dec_ext > lvl_ext) ? '0 : (lvl_ext - dec_ext);
		level_d = level_q;
		stage_d = stage_q;
		unique case (stage_q)
			svnco_pkg::ENV_ATTACK: begin
				if (att_sum > LVL_MAX) begin
					level_d = LVL_MAX[LW-1:0];
					stage_d = svnco_pkg::ENV_DECAY;
				end else begin
					level_d = att_sum[LW-1:0];
				end
			end
			svnco_pkg::ENV_DECAY: begin
				level_d = dec_lvl[LW-1:0];
				if (dec_lvl < sus_ext)
					stage_d = svnco_pkg::ENV_SUSTAIN;
			end
			svnco_pkg::ENV_RELEASE: begin
				if (rel_ext > lvl_ext) begin
					level_d = '0;
					stage_d = svnco_pkg::ENV_IDLE;
				end else begin
					level_d = LW'(lvl_ext - rel_ext);
				end
			end
			default: ;  // idle and sustain hold the level
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= '0;
			phase_step_q <= '0;
			level_q      <= '0;
			stage_q      <= svnco_pkg::ENV_IDLE;
		end else if (accept) begin
			case (op)
				svnco_pkg::OP_TICK: begin
					phase_q <= phase_q + phase_step_q;  // wraps mod 2^15
					level_q <= level_d;
					stage_q <= stage_d;
				end
				svnco_pkg::OP_NOTE_ON: begin
					// attack restarts from the current level
					phase_step_q <= phase_increment;
					stage_q      <= svnco_pkg::ENV_ATTACK;
				end
				svnco_pkg::OP_NOTE_OFF: begin
					stage_q <= svnco_pkg::ENV_RELEASE;
				end
				default: ;  // unused op: no effect
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Sample pipeline
	// s1: snapshot of phase and level before the step (level forced to
	//     zero while idle so the sample comes out zero)
	// s2: wave value (table lookup and interpolation)
	// s3: wave * level
	// s4: magnitude, drop level fraction bits
	// s5: quotient estimate for /32767
	// out: quotient correction, sign, clamp
	// ------------------------------------------------------------------
	logic [svnco_pkg::PHASE_BITS-1:0] phase_s1;
	logic [LW-1:0]                    level_s1;
	logic [2:0]                       stage_s1;

	logic signed [15:0]               w_s2;
	logic [LW-1:0]                    level_s2;
	logic [2:0]                       stage_s2;

	logic signed [PW-1:0]             prod_s3;
	logic [2:0]                       stage_s3;

	logic [30:0]                      mag_s4;
	logic                             neg_s4;
	logic [2:0]                       stage_s4;

	logic [30:0]                      mag_s5;
	logic [16:0]                      q0_s5;
	logic                             neg_s5;
	logic [2:0]                       stage_s5;

	logic signed [15:0]               sample_q;
	logic [2:0]                       result_stage_q;

	// sine lookup: quarter table with quadrant folding
	function automatic logic signed [15:0] sine_at(input logic [IB-1:0] j);
		logic [1:0]    quad;
		logic [IB-3:0] r;
		logic [IB-2:0] k;
		logic [14:0]   m;
		quad = j[IB-1 -: 2];
		r    = j[IB-3:0];
		k    = quad[0] ? ((IB-1)'(svnco_pkg::SINE_QTR) - {1'b0, r}) : {1'b0, r};
		m    = svnco_pkg::SINE_QTAB[k];
		return quad[1] ? -$signed({1'b0, m}) : $signed({1'b0, m});
	endfunction

	// s2 combinational: wave value
	logic [IB-1:0]          idx_c;
	logic [IB-1:0]          idx_nx_c;
	logic [14:0]            frac_c;
	logic signed [15:0]     tab_a_c;
	logic signed [15:0]     tab_b_c;
	logic signed [16:0]     diff_c;
	logic signed [32:0]     interp_p_c;
	logic signed [17:0]     interp_w_c;
	logic signed [15:0]     wave_c;

	always_comb begin
		idx_c      = phase_s1[14 -: IB];
		idx_nx_c   = idx_c + 1'b1;  // wraps to entry 0 at the period end
		frac_c     = 15'(phase_s1 << IB);
		tab_a_c    = sine_at(idx_c);
		tab_b_c    = sine_at(idx_nx_c);
		diff_c     = 17'(tab_b_c) - 17'(tab_a_c);
		// a + floor((b-a)*f / 32768)
		interp_p_c = 33'(diff_c) * $signed({18'd0, frac_c});
		interp_w_c = 18'(tab_a_c) + 18'(interp_p_c >>> 15);
		unique case (wave_type_q)
			svnco_pkg::WAVE_SQUARE:
				wave_c = (phase_s1 > svnco_pkg::SQUARE_EDGE) ? svnco_pkg::WAVE_MAX
				                                             : svnco_pkg::WAVE_MIN;
			svnco_pkg::WAVE_SAW:
				wave_c = $signed({1'b0, phase_s1});
			default:
				wave_c = interp_w_c[15:0];  // sine, also for the unused code
		endcase
	end

	// s3 combinational: product
	logic signed [PW-1:0] prod_c;
	assign prod_c = PW'(w_s2) * $signed({1'b0, level_s2});

	// s4 combinational: magnitude >> fraction bits (truncation toward zero)
	logic [PW-1:0] abs_c;
	logic [30:0]   mag_c;
	assign abs_c = prod_s3[PW-1] ? PW'(-prod_s3) : PW'(prod_s3);
	assign mag_c = 31'(abs_c >> LEVEL_FRAC_BITS);

	// s5 combinational: x/32767 estimate, low by at most one
	logic [31:0] qsum_c;
	assign qsum_c = {1'b0, mag_s4} + 32'(mag_s4 >> 15);

	// out combinational: correct, sign, clamp
	logic [31:0]        rem_c;
	logic [16:0]        q_c;
	logic signed [15:0] sample_c;

	always_comb begin
		rem_c = {1'b0, mag_s5} - ({q0_s5, 15'd0} - 32'(q0_s5));
		q_c   = q0_s5 + 17'(rem_c >= svnco_pkg::DIV_DEN);
		if (neg_s5)
			sample_c = 16'(-q_c);
		else if (q_c > 17'(svnco_pkg::WAVE_MAX))
			sample_c = svnco_pkg::WAVE_MAX;
		else
			sample_c = q_c[15:0];
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy_s1)  v_s1        <= tick_acc;
			if (rdy_s2)  v_s2        <= v_s1;
			if (rdy_s3)  v_s3        <= v_s2;
			if (rdy_s4)  v_s4        <= v_s3;
			if (rdy_s5)  v_s5        <= v_s4;
			if (rdy_out) out_valid_q <= v_s5;
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (tick_acc) begin
			phase_s1 <= phase_q;
			level_s1 <= (stage_q == svnco_pkg::ENV_IDLE) ? '0 : level_q;
			stage_s1 <= stage_d;
		end
		if (v_s1 && rdy_s2) begin
			w_s2     <= wave_c;
			level_s2 <= level_s1;
			stage_s2 <= stage_s1;
		end
		if (v_s2 && rdy_s3) begin
			prod_s3  <= prod_c;
			stage_s3 <= stage_s2;
		end
		if (v_s3 && rdy_s4) begin
			mag_s4   <= mag_c;
			neg_s4   <= prod_s3[PW-1];
			stage_s4 <= stage_s3;
		end
		if (v_s4 && rdy_s5) begin
			mag_s5   <= mag_s4;
			q0_s5    <= qsum_c[31:15];
			neg_s5   <= neg_s4;
			stage_s5 <= stage_s4;
		end
		if (v_s5 && rdy_out) begin
			sample_q       <= sample_c;
			result_stage_q <= stage_s5;
		end
	end

	assign out_valid          = out_valid_q;
	assign sample_out         = sample_q;
	assign envelope_stage_out = result_stage_q;

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the synth voice core
// Drives tick / note on / note off items through the valid-ready input,
// predicts every sample and envelope stage from a local model of the voice,
// and checks each result item in order under varied handshake pressure.
// ----------------------------------------------------------------------------
module tb;

	// Unused opcode value: the voice must ignore it
	localparam logic [1:0]      OP_UNUSED   = 2'd3;
	localparam int              SINE_N      = svnco_pkg::SINE_TABLE_SIZE;
	localparam int              FRAC        = svnco_pkg::LEVEL_FRAC_BITS;
	// Full-scale level, Q15 max with the extra fraction bits
	localparam longint          LEVEL_TOP   = 64'sd32767 <<< FRAC;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint          ONE_Q30     = 64'sd1 <<< 30;
	// Idle drain period that covers the trailing pipeline
	localparam int              DRAIN_CYCLES = 12;
	localparam int              CYCLE_LIMIT  = 300000;

	typedef struct packed {
		logic signed [15:0]    sample;
		svnco_pkg::env_stage_t stage;
	} voice_result_t;

	logic                                    clk = 1'b0;
	logic                                    arst_n;
	logic                                    cfg_we;
	logic [svnco_pkg::CFG_INDEX_BITS-1:0]    cfg_index;
	logic [svnco_pkg::CFG_DATA_BITS-1:0]     cfg_data;
	logic                                    in_valid;
	logic                                    in_ready;
	logic [1:0]                              op;
	logic [svnco_pkg::PHASE_BITS-1:0]        phase_increment;
	logic                                    out_valid;
	logic                                    out_ready;
	logic signed [svnco_pkg::SAMPLE_BITS-1:0] sample_out;
	logic [2:0]                              envelope_stage_out;

	// Local copy of the voice: oscillator, envelope and register values
	int                    sine_points [0:SINE_N];
	logic [14:0]           osc_phase;
	logic [14:0]           osc_step;
	longint                env_level;
	svnco_pkg::env_stage_t env_stage;
	logic [1:0]            wave_sel;
	longint                attack_inc;
	longint                decay_dec;
	longint                release_dec;
	longint                sustain_q15;

	voice_result_t pending_results[$];

	int errors           = 0;
	int items_sent       = 0;
	int samples_checked  = 0;
	int settings_applied = 0;
	int cycle_count      = 0;
	int send_idle_pct    = 0;
	int recv_stall_pct   = 0;

	synth_voice_nco_with_adsr_core dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg_we),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.op                 (op),
		.phase_increment    (phase_increment),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.sample_out         (sample_out),
		.envelope_stage_out (envelope_stage_out)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Run guard
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("simulation failed");
			$finish;
		end
	end

	// Result side: random stalls on out_ready
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Result checker: every accepted result item against the oldest prediction
	always @(posedge clk) begin : result_check
		voice_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("result with none pending: sample_out %0d envelope_stage_out %0d",
					sample_out, envelope_stage_out);
				errors++;
			end else begin
				want = pending_results.pop_front();
				samples_checked++;
				if (sample_out !== want.sample) begin
					$error("sample_out: expected %0d, got %0d", want.sample, sample_out);
					errors++;
				end
				if (envelope_stage_out !== want.stage) begin
					$error("envelope_stage_out: expected %0d, got %0d",
						want.stage, envelope_stage_out);
					errors++;
				end
			end
		end
	end

	// Sine point j of the full period: Q30 Taylor series to x^13, folded by
	// quadrant, clamped to [0,1] and rounded to Q15
	function automatic int sine_point(int j);
		longint unsigned quad;
		longint unsigned num;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint          acc;
		int              v;
		quad = (j % SINE_N) * 4 / SINE_N;
		num  = 4 * (j % (SINE_N / 4));
		if (quad[0])
			num = SINE_N - num;
		x    = HALF_PI_Q30 * num / SINE_N;
		x2   = (x * x) >> 30;
		term = x;
		acc  = x;
		for (int k = 1; k <= 6; k++) begin
			term = ((term * x2) >> 30) / (2 * k * (2 * k + 1));
			acc  = (k % 2) ? acc - longint'(term) : acc + longint'(term);
		end
		if (acc < 0)
			acc = 0;
		if (acc > ONE_Q30)
			acc = ONE_Q30;
		v = int'((acc * 32767 + (64'sd1 <<< 29)) >>> 30);
		return (quad >= 2) ? -v : v;
	endfunction

	// Linear interpolation between neighboring table points, floored
	function automatic int sine_at(logic [14:0] ph);
		longint p;
		longint frac;
		longint s;
		int     idx;
		p    = longint'(ph) * SINE_N;
		idx  = int'(p >> 15);
		frac = p & 64'h7fff;
		s    = sine_points[idx] * (32768 - frac) + sine_points[idx + 1] * frac;
		return int'(s >>> 15);
	endfunction

	function automatic int wave_at(logic [14:0] ph);
		case (wave_sel)
			svnco_pkg::WAVE_SQUARE: return (ph > svnco_pkg::SQUARE_EDGE) ? 32767 : -32768;
			svnco_pkg::WAVE_SAW:    return int'(ph);
			default:                return sine_at(ph);   // the spare code plays sine too
		endcase
	endfunction

	// One sample tick: sample from the level before the step, then advance
	// the phase and take one envelope step
	function automatic voice_result_t voice_tick();
		voice_result_t r;
		longint        smp;
		smp = 0;
		if (env_stage != svnco_pkg::ENV_IDLE) begin
			smp = longint'(wave_at(osc_phase)) * env_level / LEVEL_TOP;
			if (smp > 32767)
				smp = 32767;
			if (smp < -32768)
				smp = -32768;
		end
		osc_phase = osc_phase + osc_step;
		case (env_stage)
			svnco_pkg::ENV_ATTACK: begin
				env_level = env_level + attack_inc;
				if (env_level > LEVEL_TOP) begin
					env_level = LEVEL_TOP;
					env_stage = svnco_pkg::ENV_DECAY;
				end
			end
			svnco_pkg::ENV_DECAY: begin
				env_level = (decay_dec > env_level) ? 0 : env_level - decay_dec;
				if (env_level < (sustain_q15 <<< FRAC))
					env_stage = svnco_pkg::ENV_SUSTAIN;
			end
			svnco_pkg::ENV_RELEASE: begin
				if (release_dec > env_level) begin
					env_level = 0;
					env_stage = svnco_pkg::ENV_IDLE;
				end else begin
					env_level = env_level - release_dec;
				end
			end
			default: ;
		endcase
		r.sample = 16'(smp);
		r.stage  = env_stage;
		return r;
	endfunction

	function automatic void predict_item(logic [1:0] code, logic [14:0] inc);
		case (code)
			svnco_pkg::OP_NOTE_ON: begin
				osc_step  = inc;
				env_stage = svnco_pkg::ENV_ATTACK;
			end
			svnco_pkg::OP_NOTE_OFF: env_stage = svnco_pkg::ENV_RELEASE;
			svnco_pkg::OP_TICK:     pending_results.push_back(voice_tick());
			default: ;
		endcase
	endfunction

	// Send one item: optional idle gap (junk payload while invalid), then hold
	// valid until the handshake completes
	task automatic send_item(logic [1:0] code, logic [14:0] inc);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid        <= 1'b0;
			op              <= 2'($urandom);
			phase_increment <= 15'($urandom);
			@(posedge clk);
		end
		in_valid        <= 1'b1;
		op              <= code;
		phase_increment <= inc;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_item(code, inc);
		if (code != OP_UNUSED)
			items_sent++;
	endtask

	task automatic send_ticks(int n);
		repeat (n)
			send_item(svnco_pkg::OP_TICK, 15'($urandom));
	endtask

	// Quiesce: input idle, all predicted results seen, pipeline flushed
	task automatic drain_voice();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
	endtask

	// Register write, only called while the voice is quiet
	task automatic write_reg(svnco_pkg::cfg_index_t idx, logic [30:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		@(posedge clk);
		case (idx)
			svnco_pkg::CFG_WAVE_TYPE:     wave_sel    = val[1:0];
			svnco_pkg::CFG_ATTACK_STEP:   attack_inc  = val;
			svnco_pkg::CFG_DECAY_STEP:    decay_dec   = val;
			svnco_pkg::CFG_RELEASE_STEP:  release_dec = val;
			svnco_pkg::CFG_SUSTAIN_LEVEL: sustain_q15 = val[14:0];
			default: ;
		endcase
		settings_applied++;
	endtask

	task automatic write_all(logic [1:0] wave, logic [30:0] atk, logic [30:0] dcy,
			logic [30:0] rel, logic [14:0] sus);
		write_reg(svnco_pkg::CFG_WAVE_TYPE, 31'(wave));
		write_reg(svnco_pkg::CFG_ATTACK_STEP, atk);
		write_reg(svnco_pkg::CFG_DECAY_STEP, dcy);
		write_reg(svnco_pkg::CFG_RELEASE_STEP, rel);
		write_reg(svnco_pkg::CFG_SUSTAIN_LEVEL, 31'(sus));
	endtask

	// Mostly steps that finish a stage within a few dozen ticks, plus extremes
	function automatic logic [30:0] random_step();
		case ($urandom_range(9))
			0:       return '0;
			1:       return '1;
			2:       return 31'($urandom);
			default: return 31'(LEVEL_TOP / $urandom_range(1, 48));
		endcase
	endfunction

	function automatic logic [14:0] random_sustain();
		case ($urandom_range(3))
			0:       return '0;
			1:       return '1;
			default: return 15'($urandom);
		endcase
	endfunction

	function automatic logic [14:0] random_increment();
		case ($urandom_range(9))
			0:       return '0;
			1:       return '1;
			default: return 15'($urandom);
		endcase
	endfunction

	// Defaults after reset: idle ticks, ignored opcode, note off while idle,
	// then the start of a default attack on the sine wave
	task automatic test_reset_state();
		send_ticks(2);
		send_item(OP_UNUSED, 15'h5555);
		send_item(svnco_pkg::OP_NOTE_OFF, 15'h0);
		send_ticks(1);
		send_item(svnco_pkg::OP_NOTE_ON, 15'h0155);
		send_ticks(3);
	endtask

	// Register extremes: one-tick attack, one-tick decay to a zero level,
	// one-tick release; then all steps zero with a frozen phase
	task automatic test_extreme_settings();
		drain_voice();
		write_all(svnco_pkg::WAVE_SQUARE, '1, '1, '1, '1);
		send_item(svnco_pkg::OP_NOTE_ON, 15'h7fff);
		send_ticks(3);
		send_item(svnco_pkg::OP_NOTE_OFF, 15'h2aaa);
		send_ticks(1);
		drain_voice();
		write_all(svnco_pkg::WAVE_SAW, '0, '0, '0, '0);
		send_item(svnco_pkg::OP_NOTE_ON, 15'h0);
		send_ticks(2);
		send_item(svnco_pkg::OP_NOTE_OFF, 15'h0);
		send_ticks(2);
	endtask

	// Spare wave code, decay that never ends, retrigger from full level,
	// release with a zero step holding the level
	task automatic test_open_cases();
		drain_voice();
		write_reg(svnco_pkg::CFG_WAVE_TYPE, 31'd3);
		write_reg(svnco_pkg::CFG_ATTACK_STEP, '1);
		write_reg(svnco_pkg::CFG_SUSTAIN_LEVEL, 31'h7fff);
		send_item(svnco_pkg::OP_NOTE_ON, 15'h2000);
		send_ticks(3);
		send_item(svnco_pkg::OP_NOTE_ON, 15'h0);
		send_ticks(1);
		send_item(svnco_pkg::OP_NOTE_OFF, 15'h1234);
		send_ticks(2);
		send_item(OP_UNUSED, 15'h7fff);
	endtask

	// Note sequences with random content, plus some random noise items
	task automatic play_random_notes(int n);
		int start;
		start = items_sent;
		while (items_sent - start < n) begin
			if ($urandom_range(99) < 80) begin
				send_item(svnco_pkg::OP_NOTE_ON, random_increment());
				send_ticks($urandom_range(60));
				send_item(svnco_pkg::OP_NOTE_OFF, 15'($urandom));
				send_ticks($urandom_range(40));
			end else begin
				repeat ($urandom_range(1, 8))
					send_item(2'($urandom), 15'($urandom));
			end
		end
	endtask

	// Eight random phases, each with fresh register values, cycling through
	// the handshake pressure mixes
	task automatic test_random_voices();
		for (int ph = 0; ph < 8; ph++) begin
			drain_voice();
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
				default: begin send_idle_pct = 28; recv_stall_pct = 28; end
			endcase
			write_all(2'($urandom_range(3)), random_step(), random_step(),
				random_step(), random_sustain());
			play_random_notes(180);
		end
	endtask

	initial begin
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = svnco_pkg::CFG_WAVE_TYPE;
		cfg_data        = '0;
		in_valid        = 1'b0;
		op              = svnco_pkg::OP_TICK;
		phase_increment = '0;
		out_ready       = 1'b0;

		for (int j = 0; j <= SINE_N; j++)
			sine_points[j] = sine_point(j);
		osc_phase   = '0;
		osc_step    = '0;
		env_level   = 0;
		env_stage   = svnco_pkg::ENV_IDLE;
		wave_sel    = svnco_pkg::WAVE_SINE;
		attack_inc  = svnco_pkg::ATTACK_STEP_RST;
		decay_dec   = svnco_pkg::DECAY_STEP_RST;
		release_dec = svnco_pkg::RELEASE_STEP_RST;
		sustain_q15 = svnco_pkg::SUSTAIN_RST;

		repeat (12)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_extreme_settings();
		test_open_cases();
		test_random_voices();
		drain_voice();

		$display("sent %0d items, checked %0d samples, %0d register writes",
			items_sent, samples_checked, settings_applied);
		$display("all waves and envelope stages under four handshake pressure mixes");
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
